// ----- rtl/ionok_pkg.sv -----
package ionok_pkg;

    localparam int VALUE_BITS = 48;
    localparam int MAG_BITS   = VALUE_BITS - 1;
    localparam int NUM_SATS   = 64;
    localparam int SLOT_BITS  = $clog2(NUM_SATS);
    localparam int RF_DEPTH   = 64;
    localparam int RF_BITS    = $clog2(RF_DEPTH);
    localparam int CFG_BITS   = 3;

    typedef logic signed [VALUE_BITS-1:0] t_val;

    localparam t_val VMAX = t_val'({1'b0, {MAG_BITS{1'b1}}});
    localparam t_val ONE  = t_val'(65536);

    // configuration register indexes
    localparam logic [CFG_BITS-1:0] CFG_MAX_GAP   = 3'd0;
    localparam logic [CFG_BITS-1:0] CFG_CODE_W    = 3'd1;
    localparam logic [CFG_BITS-1:0] CFG_PHASE_W   = 3'd2;
    localparam logic [CFG_BITS-1:0] CFG_INIT_DVAR = 3'd3;
    localparam logic [CFG_BITS-1:0] CFG_INIT_BVAR = 3'd4;

    typedef struct packed {
        logic [31:0]         max_gap;
        logic [MAG_BITS-1:0] code_weight;
        logic [MAG_BITS-1:0] phase_weight;
        logic [MAG_BITS-1:0] init_delay_var;
        logic [MAG_BITS-1:0] init_bias_var;
    } t_cfg;

    typedef struct packed {
        logic [5:0]          sat_index;
        logic [31:0]         epoch_time;
        logic signed [47:0]  iono_code;
        logic signed [47:0]  iono_phase;
        logic signed [47:0]  delay_transition;
        logic signed [47:0]  bias_transition;
        logic [46:0]         delay_noise;
        logic [46:0]         bias_noise;
    } t_in;

    typedef struct packed {
        logic [5:0]          out_sat_index;
        logic signed [47:0]  iono_delay;
        logic signed [47:0]  phase_bias;
        logic [46:0]         delay_var;
        logic [46:0]         bias_var;
        logic                restarted;
        logic                saturated;
    } t_out;

    // normalized work item between front and back
    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [31:0]          epoch;
        t_val                 mc;
        t_val                 mp;
        t_val                 fa;
        t_val                 fb;
        t_val                 q1;
        t_val                 q2;
    } t_job;

    // per-satellite stored filter state
    typedef struct packed {
        logic [31:0] last_epoch;
        t_val        delay;
        t_val        bias;
        t_val        p11;
        t_val        p12;
        t_val        p22;
    } t_slot;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_NEG,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [RF_BITS-1:0] rd;
        logic [RF_BITS-1:0] ra;
        logic [RF_BITS-1:0] rb;
    } t_instr;

    // register file map; the first LOAD_CNT entries are loaded per item
    localparam logic [RF_BITS-1:0] R_ONE  = 6'd0;
    localparam logic [RF_BITS-1:0] R_FA   = 6'd1;
    localparam logic [RF_BITS-1:0] R_FB   = 6'd2;
    localparam logic [RF_BITS-1:0] R_MC   = 6'd3;
    localparam logic [RF_BITS-1:0] R_MP   = 6'd4;
    localparam logic [RF_BITS-1:0] R_Q1   = 6'd5;
    localparam logic [RF_BITS-1:0] R_Q2   = 6'd6;
    localparam logic [RF_BITS-1:0] R_WC   = 6'd7;
    localparam logic [RF_BITS-1:0] R_WP   = 6'd8;
    localparam logic [RF_BITS-1:0] R_D    = 6'd9;
    localparam logic [RF_BITS-1:0] R_C    = 6'd10;
    localparam logic [RF_BITS-1:0] R_P11  = 6'd11;
    localparam logic [RF_BITS-1:0] R_P12  = 6'd12;
    localparam logic [RF_BITS-1:0] R_P22  = 6'd13;
    localparam logic [RF_BITS-1:0] R_T1   = 6'd14;
    localparam logic [RF_BITS-1:0] R_T2   = 6'd15;
    localparam logic [RF_BITS-1:0] R_M11  = 6'd16;
    localparam logic [RF_BITS-1:0] R_M12  = 6'd17;
    localparam logic [RF_BITS-1:0] R_M22  = 6'd18;
    localparam logic [RF_BITS-1:0] R_X1   = 6'd19;
    localparam logic [RF_BITS-1:0] R_X2   = 6'd20;
    localparam logic [RF_BITS-1:0] R_L    = 6'd21;
    localparam logic [RF_BITS-1:0] R_S    = 6'd22;
    localparam logic [RF_BITS-1:0] R_I11  = 6'd23;
    localparam logic [RF_BITS-1:0] R_I12  = 6'd24;
    localparam logic [RF_BITS-1:0] R_I22  = 6'd25;
    localparam logic [RF_BITS-1:0] R_N11  = 6'd26;
    localparam logic [RF_BITS-1:0] R_N12  = 6'd27;
    localparam logic [RF_BITS-1:0] R_N22  = 6'd28;
    localparam logic [RF_BITS-1:0] R_G1   = 6'd29;
    localparam logic [RF_BITS-1:0] R_G2   = 6'd30;
    localparam logic [RF_BITS-1:0] R_H1   = 6'd31;
    localparam logic [RF_BITS-1:0] R_H2   = 6'd32;
    localparam logic [RF_BITS-1:0] R_NP11 = 6'd33;
    localparam logic [RF_BITS-1:0] R_NP12 = 6'd34;
    localparam logic [RF_BITS-1:0] R_NP22 = 6'd35;
    localparam logic [RF_BITS-1:0] R_ND   = 6'd36;
    localparam logic [RF_BITS-1:0] R_NC   = 6'd37;

    localparam int LOAD_CNT = 14;
    localparam int PROG_LEN = 50;

    // predict, invert prior, form information matrix, invert, update state
    localparam t_instr PROG [PROG_LEN] = '{
        '{OP_MUL, R_T1,   R_FA,   R_P11},
        '{OP_MUL, R_T1,   R_T1,   R_FA },
        '{OP_ADD, R_M11,  R_T1,   R_Q1 },
        '{OP_MUL, R_T1,   R_FA,   R_P12},
        '{OP_MUL, R_M12,  R_T1,   R_FB },
        '{OP_MUL, R_T1,   R_FB,   R_P22},
        '{OP_MUL, R_T1,   R_T1,   R_FB },
        '{OP_ADD, R_M22,  R_T1,   R_Q2 },
        '{OP_MUL, R_X1,   R_FA,   R_D  },
        '{OP_MUL, R_X2,   R_FB,   R_C  },
        '{OP_DIV, R_L,    R_M12,  R_M11},
        '{OP_MUL, R_T1,   R_L,    R_M12},
        '{OP_SUB, R_S,    R_M22,  R_T1 },
        '{OP_DIV, R_I22,  R_ONE,  R_S  },
        '{OP_MUL, R_T1,   R_L,    R_I22},
        '{OP_NEG, R_I12,  R_T1,   R_ONE},
        '{OP_DIV, R_T2,   R_ONE,  R_M11},
        '{OP_MUL, R_T1,   R_L,    R_I12},
        '{OP_SUB, R_I11,  R_T2,   R_T1 },
        '{OP_ADD, R_T1,   R_WC,   R_WP },
        '{OP_ADD, R_N11,  R_T1,   R_I11},
        '{OP_NEG, R_T1,   R_WP,   R_ONE},
        '{OP_ADD, R_N12,  R_T1,   R_I12},
        '{OP_ADD, R_N22,  R_WP,   R_I22},
        '{OP_DIV, R_L,    R_N12,  R_N11},
        '{OP_MUL, R_T1,   R_L,    R_N12},
        '{OP_SUB, R_S,    R_N22,  R_T1 },
        '{OP_DIV, R_NP22, R_ONE,  R_S  },
        '{OP_MUL, R_T1,   R_L,    R_NP22},
        '{OP_NEG, R_NP12, R_T1,   R_ONE},
        '{OP_DIV, R_T2,   R_ONE,  R_N11},
        '{OP_MUL, R_T1,   R_L,    R_NP12},
        '{OP_SUB, R_NP11, R_T2,   R_T1 },
        '{OP_MUL, R_G2,   R_WP,   R_MP },
        '{OP_MUL, R_T1,   R_WC,   R_MC },
        '{OP_SUB, R_G1,   R_T1,   R_G2 },
        '{OP_MUL, R_T1,   R_I11,  R_X1 },
        '{OP_MUL, R_T2,   R_I12,  R_X2 },
        '{OP_ADD, R_T1,   R_T1,   R_T2 },
        '{OP_ADD, R_H1,   R_G1,   R_T1 },
        '{OP_MUL, R_T1,   R_I12,  R_X1 },
        '{OP_MUL, R_T2,   R_I22,  R_X2 },
        '{OP_ADD, R_T1,   R_T1,   R_T2 },
        '{OP_ADD, R_H2,   R_G2,   R_T1 },
        '{OP_MUL, R_T1,   R_NP11, R_H1 },
        '{OP_MUL, R_T2,   R_NP12, R_H2 },
        '{OP_ADD, R_ND,   R_T1,   R_T2 },
        '{OP_MUL, R_T1,   R_NP12, R_H1 },
        '{OP_MUL, R_T2,   R_NP22, R_H2 },
        '{OP_ADD, R_NC,   R_T1,   R_T2 }
    };

    // map the most negative code to -VMAX
    function automatic t_val clampv(input t_val v);
        t_val r;
        r = v;
        if (v[VALUE_BITS-1] && (v[MAG_BITS-1:0] == '0)) begin
            r = t_val'(-VMAX);
        end
        return r;
    endfunction

    // magnitude of a value known to lie within +-VMAX
    function automatic logic [MAG_BITS-1:0] mag(input t_val v);
        t_val n;
        n = t_val'(-v);
        return v[VALUE_BITS-1] ? n[MAG_BITS-1:0] : v[MAG_BITS-1:0];
    endfunction

endpackage

// ----- rtl/iono_delay_kalman_update.sv -----
// The back end runs a 50-step program on one sequencer, one item at a time: six
// 63-step serial divisions, 24 products from a 24x24 multiplier in four passes, and
// 20 add/sub/negate steps, besides reading the slot, checking restart, loading
// operands, fetching each instruction and writing back. A zero divisor ends its
// division early. A two-item queue takes start while the back end works; busy means
// it is full; the receiver cannot stall o_strobe. Sync reset clears slot valid bits
// and the queue and restores the config defaults.
module iono_delay_kalman_update (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ionok_pkg::t_in                   i_item,
    output logic                             o_strobe,
    output ionok_pkg::t_out                  o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ionok_pkg::CFG_BITS-1:0]   i_cfg_index,
    input  logic [ionok_pkg::MAG_BITS-1:0]   i_cfg_data
);

    ionok_pkg::t_cfg r_cfg;
    logic            job_valid;
    logic            job_pop;
    ionok_pkg::t_job job;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_gap        <= 32'd3600;
            r_cfg.code_weight    <= 47'd65536;
            r_cfg.phase_weight   <= 47'd655360000;
            r_cfg.init_delay_var <= 47'd65536000000;
            r_cfg.init_bias_var  <= 47'd65536000000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ionok_pkg::CFG_MAX_GAP:   r_cfg.max_gap        <= i_cfg_data[31:0];
                ionok_pkg::CFG_CODE_W:    r_cfg.code_weight    <= i_cfg_data;
                ionok_pkg::CFG_PHASE_W:   r_cfg.phase_weight   <= i_cfg_data;
                ionok_pkg::CFG_INIT_DVAR: r_cfg.init_delay_var <= i_cfg_data;
                ionok_pkg::CFG_INIT_BVAR: r_cfg.init_bias_var  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ionok_fe u_fe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_item     (i_item),
        .o_job_valid(job_valid),
        .i_job_pop  (job_pop),
        .o_job      (job)
    );

    ionok_be u_be (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_job_valid(job_valid),
        .o_job_pop  (job_pop),
        .i_job      (job),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

// ----- rtl/ionok_ram.sv -----
module ionok_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write one entry, register both reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- rtl/ionok_fe.sv -----
module ionok_fe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  ionok_pkg::t_in      i_item,
    output logic                o_job_valid,
    input  logic                i_job_pop,
    output ionok_pkg::t_job     o_job
);

    ionok_pkg::t_job r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    ionok_pkg::t_job job_in;
    logic            push;
    logic            pop;

    assign o_busy      = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign push        = i_start && !o_busy;
    assign pop         = i_job_pop && o_job_valid;

    // normalize the incoming transaction
    always_comb begin
        job_in.slot  = i_item.sat_index[ionok_pkg::SLOT_BITS-1:0];
        job_in.epoch = i_item.epoch_time;
        job_in.mc    = ionok_pkg::clampv(i_item.iono_code);
        job_in.mp    = ionok_pkg::clampv(i_item.iono_phase);
        job_in.fa    = ionok_pkg::clampv(i_item.delay_transition);
        job_in.fb    = ionok_pkg::clampv(i_item.bias_transition);
        job_in.q1    = ionok_pkg::t_val'({1'b0, i_item.delay_noise});
        job_in.q2    = ionok_pkg::t_val'({1'b0, i_item.bias_noise});
    end

    // two-entry queue toward the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= job_in;
                r_wp      <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/ionok_mul.sv -----
module ionok_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ionok_pkg::t_val     i_a,
    input  ionok_pkg::t_val     i_b,
    output logic                o_done,
    output ionok_pkg::t_val     o_res,
    output logic                o_sat
);

    localparam int VB = ionok_pkg::VALUE_BITS;
    localparam int HB = VB / 2;
    localparam int MB = ionok_pkg::MAG_BITS;

    logic [VB-1:0]   r_x;
    logic [VB-1:0]   r_y;
    logic            r_neg;
    logic [2*VB-1:0] r_acc;
    logic [1:0]      r_step;
    logic            r_run;
    logic            r_done;
    logic [HB-1:0]   xs;
    logic [HB-1:0]   ys;
    logic [VB-1:0]   pp;
    logic [2*VB-1:0] pp_sh;
    logic [1:0]      sh;
    logic [MB-1:0]   rmag;

    // pick one partial product per cycle
    always_comb begin
        xs    = r_step[0] ? r_x[VB-1:HB] : r_x[HB-1:0];
        ys    = r_step[1] ? r_y[VB-1:HB] : r_y[HB-1:0];
        pp    = xs * ys;
        sh    = {1'b0, r_step[0]} + {1'b0, r_step[1]};
        case (sh)
            2'd0:    pp_sh = {{VB{1'b0}}, pp};
            2'd1:    pp_sh = {{HB{1'b0}}, pp, {HB{1'b0}}};
            default: pp_sh = {pp, {VB{1'b0}}};
        endcase
    end

    // accumulate four partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= {1'b0, ionok_pkg::mag(i_a)};
                r_y    <= {1'b0, ionok_pkg::mag(i_b)};
                r_neg  <= i_a[VB-1] ^ i_b[VB-1];
                r_acc  <= '0;
                r_step <= 2'd0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_acc  <= r_acc + pp_sh;
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // scale by 2^-16 and saturate
    always_comb begin
        o_sat = |r_acc[2*VB-1:MB+16];
        rmag  = o_sat ? ionok_pkg::VMAX[MB-1:0] : r_acc[MB+15:16];
        o_res = r_neg ? ionok_pkg::t_val'(-{1'b0, rmag}) : ionok_pkg::t_val'({1'b0, rmag});
    end

    assign o_done = r_done;

endmodule

// ----- rtl/ionok_div.sv -----
module ionok_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ionok_pkg::t_val     i_n,
    input  ionok_pkg::t_val     i_d,
    output logic                o_done,
    output ionok_pkg::t_val     o_res,
    output logic                o_sat
);

    localparam int VB    = ionok_pkg::VALUE_BITS;
    localparam int MB    = ionok_pkg::MAG_BITS;
    localparam int QB    = MB + 16;
    localparam int CB    = $clog2(QB);

    logic [QB-1:0] r_un;
    logic [MB-1:0] r_ud;
    logic [MB-1:0] r_rem;
    logic [QB-1:0] r_q;
    logic [CB-1:0] r_cnt;
    logic          r_run;
    logic          r_done;
    logic          r_neg;
    logic          r_nneg;
    logic          r_zero;
    logic          r_nz;
    logic [MB:0]   rem2;
    logic          ge;
    logic [MB:0]   diff;
    logic          qsat;
    logic [MB-1:0] qmag;

    // one restoring step per cycle
    always_comb begin
        rem2 = {r_rem, r_un[QB-1]};
        ge   = (rem2 >= {1'b0, r_ud});
        diff = rem2 - {1'b0, r_ud};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_un   <= {ionok_pkg::mag(i_n), 16'b0};
                r_ud   <= ionok_pkg::mag(i_d);
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= '0;
                r_neg  <= i_n[VB-1] ^ i_d[VB-1];
                r_nneg <= i_n[VB-1];
                r_zero <= (i_d == '0);
                r_nz   <= (i_n != '0);
                if (i_d == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                r_rem <= ge ? diff[MB-1:0] : rem2[MB-1:0];
                r_q   <= {r_q[QB-2:0], ge};
                r_un  <= {r_un[QB-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CB'(QB - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // saturate the quotient, handle a zero divisor
    always_comb begin
        qsat = |r_q[QB-1:MB];
        qmag = qsat ? ionok_pkg::VMAX[MB-1:0] : r_q[MB-1:0];
        if (r_zero) begin
            o_sat = r_nz;
            if (!r_nz) begin
                o_res = '0;
            end else begin
                o_res = r_nneg ? ionok_pkg::t_val'(-ionok_pkg::VMAX) : ionok_pkg::VMAX;
            end
        end else begin
            o_sat = qsat;
            o_res = r_neg ? ionok_pkg::t_val'(-{1'b0, qmag}) : ionok_pkg::t_val'({1'b0, qmag});
        end
    end

    assign o_done = r_done;

endmodule

// ----- rtl/ionok_be.sv -----
module ionok_be (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ionok_pkg::t_cfg     i_cfg,
    input  logic                i_job_valid,
    output logic                o_job_pop,
    input  ionok_pkg::t_job     i_job,
    output logic                o_strobe,
    output ionok_pkg::t_out     o_result
);

    localparam int VB = ionok_pkg::VALUE_BITS;
    localparam int MB = ionok_pkg::MAG_BITS;
    localparam int SW = $bits(ionok_pkg::t_slot);
    localparam logic signed [VB:0] LIM = {1'b0, ionok_pkg::VMAX};

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SEL,
        S_LOAD,
        S_FETCH,
        S_EXEC,
        S_DONE
    } t_state;

    t_state                       r_state;
    ionok_pkg::t_job              r_job;
    logic                         r_restart;
    logic [3:0]                   r_cnt;
    logic [ionok_pkg::RF_BITS-1:0] r_pc;
    logic                         r_wait;
    logic                         r_sat;
    ionok_pkg::t_val              r_np11;
    ionok_pkg::t_val              r_np12;
    ionok_pkg::t_val              r_np22;
    ionok_pkg::t_val              r_nd;
    ionok_pkg::t_val              r_nc;
    logic [ionok_pkg::NUM_SATS-1:0] r_valid;
    logic                         r_strobe;
    ionok_pkg::t_out              r_result;

    ionok_pkg::t_instr            instr;
    logic [SW-1:0]                slot_raw;
    ionok_pkg::t_slot             slot_rd;
    ionok_pkg::t_slot             slot_wr;
    ionok_pkg::t_val              ra;
    ionok_pkg::t_val              rb;
    logic                         rf_we;
    logic [ionok_pkg::RF_BITS-1:0] rf_waddr;
    ionok_pkg::t_val              rf_wdata;
    ionok_pkg::t_val              load_val;
    logic [VB:0]                  alu;
    logic                         is_long;
    logic                         mul_start;
    logic                         div_start;
    logic                         mul_done;
    logic                         div_done;
    ionok_pkg::t_val              mul_res;
    ionok_pkg::t_val              div_res;
    logic                         mul_sat;
    logic                         div_sat;
    logic                         exec_done;
    ionok_pkg::t_val              exec_val;
    logic                         exec_sat;
    logic [31:0]                  gap;
    logic                         restart;
    ionok_pkg::t_out              out_next;

    function automatic logic [VB:0] sat_add(input ionok_pkg::t_val a,
                                            input ionok_pkg::t_val b);
        logic signed [VB:0] s;
        s = $signed({a[VB-1], a}) + $signed({b[VB-1], b});
        if (s > LIM) begin
            return {1'b1, ionok_pkg::VMAX};
        end else if (s < -LIM) begin
            return {1'b1, ionok_pkg::t_val'(-ionok_pkg::VMAX)};
        end
        return {1'b0, s[VB-1:0]};
    endfunction

    // per-satellite state table
    ionok_ram #(
        .WIDTH(SW),
        .DEPTH(ionok_pkg::NUM_SATS)
    ) u_state_ram (
        .i_clk    (i_clk),
        .i_we     (r_state == S_DONE),
        .i_waddr  (r_job.slot),
        .i_wdata  (slot_wr),
        .i_raddr_a(r_job.slot),
        .o_rdata_a(slot_raw),
        .i_raddr_b(r_job.slot),
        .o_rdata_b()
    );

    // working register file
    ionok_ram #(
        .WIDTH(VB),
        .DEPTH(ionok_pkg::RF_DEPTH)
    ) u_rf (
        .i_clk    (i_clk),
        .i_we     (rf_we),
        .i_waddr  (rf_waddr),
        .i_wdata  (rf_wdata),
        .i_raddr_a(instr.ra),
        .o_rdata_a(ra),
        .i_raddr_b(instr.rb),
        .o_rdata_b(rb)
    );

    ionok_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_start),
        .i_a    (ra),
        .i_b    (rb),
        .o_done (mul_done),
        .o_res  (mul_res),
        .o_sat  (mul_sat)
    );

    ionok_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_n    (ra),
        .i_d    (rb),
        .o_done (div_done),
        .o_res  (div_res),
        .o_sat  (div_sat)
    );

    assign instr   = ionok_pkg::PROG[r_pc];
    assign slot_rd = ionok_pkg::t_slot'(slot_raw);

    // restart decision from the slot valid bit and the stored epoch
    always_comb begin
        if (r_job.epoch >= slot_rd.last_epoch) begin
            gap = r_job.epoch - slot_rd.last_epoch;
        end else begin
            gap = slot_rd.last_epoch - r_job.epoch;
        end
        restart = !r_valid[r_job.slot] || (gap > i_cfg.max_gap);
    end

    // select the value loaded into the register file
    always_comb begin
        case ({2'b00, r_cnt})
            ionok_pkg::R_ONE: load_val = ionok_pkg::ONE;
            ionok_pkg::R_FA:  load_val = r_job.fa;
            ionok_pkg::R_FB:  load_val = r_job.fb;
            ionok_pkg::R_MC:  load_val = r_job.mc;
            ionok_pkg::R_MP:  load_val = r_job.mp;
            ionok_pkg::R_Q1:  load_val = r_job.q1;
            ionok_pkg::R_Q2:  load_val = r_job.q2;
            ionok_pkg::R_WC:  load_val = ionok_pkg::t_val'({1'b0, i_cfg.code_weight});
            ionok_pkg::R_WP:  load_val = ionok_pkg::t_val'({1'b0, i_cfg.phase_weight});
            ionok_pkg::R_D:   load_val = r_restart ? '0 : slot_rd.delay;
            ionok_pkg::R_C:   load_val = r_restart ? '0 : slot_rd.bias;
            ionok_pkg::R_P11: load_val = r_restart ?
                                  ionok_pkg::t_val'({1'b0, i_cfg.init_delay_var}) : slot_rd.p11;
            ionok_pkg::R_P12: load_val = r_restart ? '0 : slot_rd.p12;
            ionok_pkg::R_P22: load_val = r_restart ?
                                  ionok_pkg::t_val'({1'b0, i_cfg.init_bias_var}) : slot_rd.p22;
            default:          load_val = '0;
        endcase
    end

    // execute one instruction
    always_comb begin
        unique case (instr.op)
            ionok_pkg::OP_ADD: alu = sat_add(ra, rb);
            ionok_pkg::OP_SUB: alu = sat_add(ra, ionok_pkg::t_val'(-rb));
            ionok_pkg::OP_NEG: alu = {1'b0, ionok_pkg::t_val'(-ra)};
            default:           alu = '0;
        endcase
        is_long   = (instr.op == ionok_pkg::OP_MUL) || (instr.op == ionok_pkg::OP_DIV);
        mul_start = (r_state == S_EXEC) && !r_wait && (instr.op == ionok_pkg::OP_MUL);
        div_start = (r_state == S_EXEC) && !r_wait && (instr.op == ionok_pkg::OP_DIV);
        if (instr.op == ionok_pkg::OP_MUL) begin
            exec_val = mul_res;
            exec_sat = mul_sat;
        end else if (instr.op == ionok_pkg::OP_DIV) begin
            exec_val = div_res;
            exec_sat = div_sat;
        end else begin
            exec_val = alu[VB-1:0];
            exec_sat = alu[VB];
        end
        exec_done = (r_state == S_EXEC) &&
                    (!is_long || (r_wait && (mul_done || div_done)));
    end

    // register file write port
    always_comb begin
        if (r_state == S_LOAD) begin
            rf_we    = 1'b1;
            rf_waddr = {2'b00, r_cnt};
            rf_wdata = load_val;
        end else begin
            rf_we    = exec_done;
            rf_waddr = instr.rd;
            rf_wdata = exec_val;
        end
    end

    // state write-back and result
    always_comb begin
        slot_wr.last_epoch     = r_job.epoch;
        slot_wr.delay          = r_nd;
        slot_wr.bias           = r_nc;
        slot_wr.p11            = r_np11;
        slot_wr.p12            = r_np12;
        slot_wr.p22            = r_np22;
        out_next.out_sat_index = 6'(r_job.slot);
        out_next.iono_delay    = r_nd;
        out_next.phase_bias    = r_nc;
        out_next.delay_var     = r_np11[VB-1] ? '0 : r_np11[MB-1:0];
        out_next.bias_var      = r_np22[VB-1] ? '0 : r_np22[MB-1:0];
        out_next.restarted     = r_restart;
        out_next.saturated     = r_sat || r_np11[VB-1] || r_np22[VB-1];
    end

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_strobe  = r_strobe;
    assign o_result  = r_result;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_strobe <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_sat   <= 1'b0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    r_restart <= restart;
                    r_cnt     <= '0;
                    r_state   <= S_LOAD;
                end
                S_LOAD: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(ionok_pkg::LOAD_CNT - 1)) begin
                        r_pc    <= '0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_wait  <= 1'b0;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (mul_start || div_start) begin
                        r_wait <= 1'b1;
                    end
                    if (exec_done) begin
                        r_sat  <= r_sat | exec_sat;
                        r_wait <= 1'b0;
                        case (instr.rd)
                            ionok_pkg::R_NP11: r_np11 <= exec_val;
                            ionok_pkg::R_NP12: r_np12 <= exec_val;
                            ionok_pkg::R_NP22: r_np22 <= exec_val;
                            ionok_pkg::R_ND:   r_nd   <= exec_val;
                            ionok_pkg::R_NC:   r_nc   <= exec_val;
                            default: ;
                        endcase
                        if (r_pc == ionok_pkg::RF_BITS'(ionok_pkg::PROG_LEN - 1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_pc    <= r_pc + 1'b1;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_DONE: begin
                    r_valid[r_job.slot] <= 1'b1;
                    r_strobe            <= 1'b1;
                    r_result            <= out_next;
                    r_state             <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/ionok_chk.sv -----
module ionok_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input ionok_pkg::t_in                   i_item,
    input logic                             o_strobe,
    input ionok_pkg::t_out                  o_result,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [ionok_pkg::CFG_BITS-1:0]   i_cfg_index,
    input logic [ionok_pkg::MAG_BITS-1:0]   i_cfg_data
);

    // config channel never backpressures
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config ready dropped");

    // each transaction yields a single-cycle strobe, never two in a row
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back result strobes");

    // the queue fills only by accepting a transaction
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted start");

    // no result in the cycle right after reset
    a_no_early: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

endmodule

bind iono_delay_kalman_update ionok_chk u_chk (.*);
